// ===== rtl/core/fsa_pkg.sv =====
// fsa_pkg: widths, reset values and command/status codes of the slot allocator.
// No dependencies; imported by free_list_slot_allocator.
package fsa_pkg;

  // payload widths
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned USED_W    = 23;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;

  // pool geometry and register reset values
  localparam int unsigned SLOTS_DEFAULT  = 1024;
  localparam int unsigned SLOT_COUNT_RST = 1024;
  localparam int unsigned SLOT_SIZE_RST  = 64;

  localparam logic [USED_W-1:0] USED_MAX = 23'h7F_FFFF;

  // commands
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REBUILD = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE  = 2'd1;

endpackage

// ===== rtl/core/free_list_slot_allocator.sv =====
// free_list_slot_allocator: fixed-size slot pool kept as a LIFO free list in a link memory.
// Depends on fsa_pkg.
//
// Usage:
//   Command channel: a command (action_i, slot_i) is taken at a rising edge with
//   start_i high and busy_o low. Actions: allocate, free, rebuild the free list.
//   Result channel: done_o is high for exactly one cycle per command, carrying
//   granted_slot_o, status_o and used_bytes_o. The receiver cannot stall it;
//   a result is always taken in the cycle it appears.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is always high. Index 0 is slot_count, index 1 is slot_size.
// Sequence:
//   Free: the result comes in the cycle after the beat; busy_o stays low throughout.
//   Allocate: the head slot's link is read from the link memory (registered read port)
//   in S_POP before the head can move on; busy_o is high until then.
//   Rebuild: result in the cycle after the beat, then busy_o stays high while the
//   sweep re-chains the link memory, one slot per cycle up to the effective count.
// Reset: the reset runs a rebuild sweep over min(1024, SLOTS) slots with busy_o
//   high; config writes are taken during it.
module free_list_slot_allocator #(
  parameter int unsigned SLOTS = fsa_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command beat
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [fsa_pkg::ACTION_W-1:0]    action_i,
  input  logic [fsa_pkg::SLOT_W-1:0]      slot_i,
  // result beat
  output logic                            done_o,
  output logic [fsa_pkg::SLOT_W-1:0]      granted_slot_o,
  output logic [fsa_pkg::STATUS_W-1:0]    status_o,
  output logic [fsa_pkg::USED_W-1:0]      used_bytes_o,
  // config write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fsa_pkg::CFG_DAT_W-1:0]   cfg_data_i
);
  import fsa_pkg::*;

  // IW indexes the memory, LW also holds the empty mark (value SLOTS)
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  // common compare width for slot ports, counts and links
  localparam int unsigned CW = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int unsigned RST_LIMIT = (SLOT_COUNT_RST > SLOTS) ? SLOTS : SLOT_COUNT_RST;

  localparam logic [LW-1:0] EMPTY_LINK = LW'(SLOTS);

  // controller states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;  // waiting on the head link read
  localparam logic [1:0] S_SWEEP = 2'd2;  // re-chaining the link memory

  logic [1:0]          state_q, state_d;
  logic [LW-1:0]       head_q, head_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic [LW-1:0]       sweep_q, sweep_d;
  logic [LW-1:0]       limit_q, limit_d;
  logic                done_q, done_d;
  logic [SLOT_W-1:0]   granted_q, granted_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [COUNT_W-1:0]  slot_count_q;
  logic [SIZE_W-1:0]   slot_size_q;

  // link memory: one write port, one registered read port
  logic [LW-1:0] link_mem [SLOTS];
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic          mem_re;
  logic [LW-1:0] mem_rdata_q;

  logic              accept;
  logic [CW-1:0]     slot_cw, head_cw, cnt_cw, eff_cw;
  logic [LW-1:0]     eff_lw;
  logic              head_empty;
  logic [USED_W:0]   used_sum;
  logic [USED_W-1:0] used_add, used_sub, size_ext;
  logic [LW-1:0]     sweep_inc;

  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  assign done_o         = done_q;
  assign granted_slot_o = granted_q;
  assign status_o       = status_q;
  assign used_bytes_o   = used_q;

  // effective count clamps to the pool size
  assign slot_cw    = CW'(slot_i);
  assign head_cw    = CW'(head_q);
  assign cnt_cw     = CW'(slot_count_q);
  assign eff_cw     = (cnt_cw > CW'(SLOTS)) ? CW'(SLOTS) : cnt_cw;
  assign eff_lw     = eff_cw[LW-1:0];
  assign head_empty = (head_q >= EMPTY_LINK);

  // used-byte total: saturating add, subtract floored at zero
  assign size_ext = USED_W'(slot_size_q);
  assign used_sum = {1'b0, used_q} + {1'b0, size_ext};
  assign used_add = (used_sum > {1'b0, USED_MAX}) ? USED_MAX : used_sum[USED_W-1:0];
  assign used_sub = (used_q > size_ext) ? (used_q - size_ext) : '0;

  assign sweep_inc = sweep_q + LW'(1);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    used_d    = used_q;
    sweep_d   = sweep_q;
    limit_d   = limit_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = sweep_q[IW-1:0];
    mem_wdata = (sweep_inc < limit_q) ? sweep_inc : EMPTY_LINK;
    mem_re    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          granted_d = '0;
          status_d  = ST_OK;
          case (action_i)
            ACT_ALLOC: begin
              if (head_empty) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                granted_d = head_cw[SLOT_W-1:0];
                used_d    = used_add;
                mem_re    = 1'b1;
                state_d   = S_POP;
              end
            end
            ACT_FREE: begin
              done_d = 1'b1;
              if (slot_cw >= eff_cw) begin
                status_d = ST_RANGE;
              end else begin
                // push: freed slot links to the old head
                mem_we    = 1'b1;
                mem_waddr = slot_cw[IW-1:0];
                mem_wdata = head_q;
                head_d    = slot_cw[LW-1:0];
                used_d    = used_sub;
              end
            end
            ACT_REBUILD: begin
              done_d  = 1'b1;
              used_d  = '0;
              sweep_d = '0;
              limit_d = eff_lw;
              if (eff_lw != '0) begin
                head_d  = '0;
                state_d = S_SWEEP;
              end else begin
                head_d = EMPTY_LINK;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        head_d  = mem_rdata_q;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SWEEP: begin
        mem_we  = 1'b1;
        sweep_d = sweep_inc;
        if (sweep_inc == limit_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      head_q  <= '0;
      used_q  <= '0;
      sweep_q <= '0;
      limit_q <= LW'(RST_LIMIT);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      used_q  <= used_d;
      sweep_q <= sweep_d;
      limit_q <= limit_d;
      done_q  <= done_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= COUNT_W'(SLOT_COUNT_RST);
      slot_size_q  <= SIZE_W'(SLOT_SIZE_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SLOT_COUNT: slot_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_SLOT_SIZE:  slot_size_q  <= cfg_data_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= link_mem[head_q[IW-1:0]];
    end
  end

`ifndef NO_ASSERTIONS
  // a result only follows a command beat or the end of a pop
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(accept) || $past(state_q == S_POP)))
    else $error("result strobe without a command");

  // head is a valid slot or exactly the empty mark
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= EMPTY_LINK)
    else $error("head out of range");

  // sweep stays inside the chained region
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (sweep_q < limit_q))
    else $error("rebuild sweep past its limit");

  // an empty-pool answer hands out no slot and is not counted
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY)) |-> (granted_slot_o == '0))
    else $error("empty pool answer carries a slot");
`endif

endmodule

// ===== sim/free_list_slot_allocator_tb.sv =====
// Self-checking bench for free_list_slot_allocator: directed table, then random pool traffic.
// Checks result beats against the table or its free-list model; needs fsa_pkg and the block.
`timescale 1ns / 1ps

module testbench;
  import fsa_pkg::*;

  localparam int unsigned SLOTS = SLOTS_DEFAULT;
  localparam logic [COUNT_W-1:0] EMPTY_LINK = COUNT_W'(SLOTS);
  // action 3 has no package name; the block answers it as a no-op
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   used;
  } grant_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [ACTION_W-1:0]  action;
    logic [SLOT_W-1:0]    slot;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    bit                   typed;  // expected beat written into the row
    grant_t               want;
  } plan_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic [ACTION_W-1:0]  action_i    = ACT_ALLOC;
  logic [SLOT_W-1:0]    slot_i      = '0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_SLOT_COUNT;
  logic [CFG_DAT_W-1:0] cfg_data_i  = '0;

  logic                 busy_o;
  logic                 done_o;
  logic [SLOT_W-1:0]    granted_slot_o;
  logic [STATUS_W-1:0]  status_o;
  logic [USED_W-1:0]    used_bytes_o;
  logic                 cfg_ready_o;

  always #5 clk_i = ~clk_i;

  free_list_slot_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .slot_i         (slot_i),
    .done_o         (done_o),
    .granted_slot_o (granted_slot_o),
    .status_o       (status_o),
    .used_bytes_o   (used_bytes_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Pool model: head, link memory, used-byte total and the two registers
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] free_head;
  logic [COUNT_W-1:0] next_free [SLOTS];
  logic [USED_W-1:0]  bytes_in_use;
  logic [COUNT_W-1:0] pool_count;
  logic [SIZE_W-1:0]  pool_slot_size;

  grant_t            pending_grants[$];  // expected result beats, oldest first
  logic [SLOT_W-1:0] held_slots[$];      // slots the bench believes are handed out
  int unsigned       fail_cnt = 0;
  bit                quiet    = 1'b0;    // no idle gaps on the command side

  // counts above the pool depth clamp to the pool depth
  function automatic int unsigned live_count();
    return (pool_count > SLOTS) ? SLOTS : int'(pool_count);
  endfunction

  // re-chain 0..n-1 in order; entries from n up keep whatever they held
  function automatic void relink_pool();
    int unsigned n;
    n = live_count();
    for (int unsigned i = 0; i < n; i++)
      next_free[i] = (i + 1 < n) ? COUNT_W'(i + 1) : EMPTY_LINK;
    free_head    = (n > 0) ? '0 : EMPTY_LINK;
    bytes_in_use = '0;
  endfunction

  function automatic grant_t predict_grant(input logic [ACTION_W-1:0] act,
                                           input logic [SLOT_W-1:0] slot);
    grant_t      r;
    int unsigned sum;
    r = '0;
    case (act)
      ACT_ALLOC: begin
        if (free_head >= SLOTS) begin
          r.status = ST_EMPTY;
        end else begin
          r.granted    = free_head[SLOT_W-1:0];
          free_head    = next_free[free_head[SLOT_W-1:0]];
          sum          = bytes_in_use;
          sum         += pool_slot_size;
          bytes_in_use = (sum > USED_MAX) ? USED_MAX : USED_W'(sum);
        end
      end
      ACT_FREE: begin
        // checked against the count as it stands now, not as of the last rebuild
        if (slot >= live_count()) begin
          r.status = ST_RANGE;
        end else begin
          next_free[slot] = free_head;  // a double free just links the slot again
          free_head       = {1'b0, slot};
          bytes_in_use    = (bytes_in_use > pool_slot_size) ?
                            bytes_in_use - pool_slot_size : '0;
        end
      end
      ACT_REBUILD: relink_pool();
      default: ;
    endcase
    r.used = bytes_in_use;
    return r;
  endfunction

  function automatic void predict_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
    if (idx == REG_SLOT_COUNT)
      pool_count = data[COUNT_W-1:0];
    else if (idx == REG_SLOT_SIZE)
      pool_slot_size = data[SIZE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic plan_row_t cmd_row(input logic [ACTION_W-1:0] act,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [SLOT_W-1:0] granted,
                                        input logic [STATUS_W-1:0] status,
                                        input logic [USED_W-1:0] used);
    plan_row_t row;
    row.kind   = ROW_CMD;
    row.action = act;
    row.slot   = slot;
    row.index  = REG_SLOT_COUNT;
    row.data   = '0;
    row.typed  = 1'b1;
    row.want   = '{granted, status, used};
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] data);
    plan_row_t row;
    row.kind   = ROW_CFG;
    row.action = ACT_ALLOC;
    row.slot   = '0;
    row.index  = idx;
    row.data   = data;
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned p;
    if (quiet)
      return 0;
    p = $urandom_range(0, 99);
    if (p < 60)
      return 0;
    if (p < 92)
      return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // one command beat; start stays high into the next call when there is no gap
  task automatic issue(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot,
                       input bit typed, input grant_t want, output grant_t got);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    action_i <= act;
    slot_i   <= slot;
    do @(posedge clk_i); while (busy_o);
    got = predict_grant(act, slot);
    pending_grants.push_back(typed ? want : got);
  endtask

  // predicted beat plus bookkeeping of handed-out slots
  task automatic send(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot);
    grant_t got;
    issue(act, slot, 1'b0, '0, got);
    if (act == ACT_ALLOC && got.status == ST_OK)
      held_slots.push_back(got.granted);
    else if (act == ACT_REBUILD)
      held_slots.delete();
  endtask

  // drop start and wait for every result and for the rebuild sweep to finish
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_grants.size() != 0 || busy_o);
    repeat (2) @(posedge clk_i);
  endtask

  // register writes only land on an idle block
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    predict_cfg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver never stalls, every done beat is checked here
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    grant_t want;
    if (rst_ni && done_o) begin
      if (pending_grants.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("ERROR %0t: result beat with none outstanding: slot %0d status %0d used %0d",
                   $realtime, granted_slot_o, status_o, used_bytes_o);
      end else begin
        want = pending_grants.pop_front();
        if (granted_slot_o !== want.granted || status_o !== want.status ||
            used_bytes_o !== want.used) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("ERROR %0t: expected slot %0d status %0d used %0d, got slot %0d status %0d used %0d",
                     $realtime, want.granted, want.status, want.used,
                     granted_slot_o, status_o, used_bytes_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t         plan[$];
    grant_t            got;
    logic [SLOT_W-1:0] pick;
    int unsigned       r;
    int unsigned       sel;
    int unsigned       idx;
    int unsigned       lim;

    // model reset: all links empty, then the reset rebuild at full count
    pool_count     = COUNT_W'(SLOT_COUNT_RST);
    pool_slot_size = SIZE_W'(SLOT_SIZE_RST);
    for (int unsigned i = 0; i < SLOTS; i++)
      next_free[i] = EMPTY_LINK;
    relink_pool();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Reset pool: 1024 slots of 64 bytes chained 0,1,2,...
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd0,    ST_OK,    23'd64));
    plan.push_back(cmd_row(ACT_ALLOC,   10'd1023, 10'd1,    ST_OK,    23'd128));
    plan.push_back(cmd_row(ACT_FREE,    10'd1023, 10'd0,    ST_OK,    23'd64));   // top slot
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd1023, ST_OK,    23'd128));  // LIFO
    plan.push_back(cmd_row(ACT_FREE,    10'd0,    10'd0,    ST_OK,    23'd64));
    plan.push_back(cmd_row(ACT_FREE,    10'd0,    10'd0,    ST_OK,    23'd0));    // double free
    plan.push_back(cmd_row(ACT_FREE,    10'd5,    10'd0,    ST_OK,    23'd0));    // floor at zero
    plan.push_back(cmd_row(ACT_UNUSED,  10'd1023, 10'd0,    ST_OK,    23'd0));
    plan.push_back(cmd_row(ACT_REBUILD, 10'd0,    10'd0,    ST_OK,    23'd0));
    // zero count: rebuild leaves nothing to hand out, every free is out of range
    plan.push_back(reg_row(REG_SLOT_COUNT, 13'd0));
    plan.push_back(cmd_row(ACT_REBUILD, 10'd0,    10'd0,    ST_OK,    23'd0));
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd0,    ST_EMPTY, 23'd0));
    plan.push_back(cmd_row(ACT_FREE,    10'd0,    10'd0,    ST_RANGE, 23'd0));
    // count above the pool depth clamps; a free refills the empty pool
    plan.push_back(reg_row(REG_SLOT_COUNT, 13'd2047));
    plan.push_back(cmd_row(ACT_FREE,    10'd1023, 10'd0,    ST_OK,    23'd0));
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd1023, ST_OK,    23'd64));
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd0,    ST_EMPTY, 23'd64));
    // size extremes
    plan.push_back(reg_row(REG_SLOT_SIZE, 13'd4096));
    plan.push_back(cmd_row(ACT_REBUILD, 10'd0,    10'd0,    ST_OK,    23'd0));
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd0,    ST_OK,    23'd4096));
    plan.push_back(reg_row(REG_SLOT_SIZE, 13'd8));
    plan.push_back(cmd_row(ACT_FREE,    10'd0,    10'd0,    ST_OK,    23'd4088));
    // count shrinks without a rebuild: old chain still hands out slot 1,
    // but freeing it is now out of range
    plan.push_back(reg_row(REG_SLOT_COUNT, 13'd1));
    plan.push_back(cmd_row(ACT_FREE,    10'd1,    10'd0,    ST_RANGE, 23'd4088));
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd0,    ST_OK,    23'd4096));
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd1,    ST_OK,    23'd4104));
    plan.push_back(cmd_row(ACT_FREE,    10'd1,    10'd0,    ST_RANGE, 23'd4104));
    // single-slot pool
    plan.push_back(cmd_row(ACT_REBUILD, 10'd0,    10'd0,    ST_OK,    23'd0));
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd0,    ST_OK,    23'd8));
    plan.push_back(cmd_row(ACT_ALLOC,   10'd0,    10'd0,    ST_EMPTY, 23'd8));
    plan.push_back(cmd_row(ACT_FREE,    10'd0,    10'd0,    ST_OK,    23'd0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].index, plan[i].data);
      else
        issue(plan[i].action, plan[i].slot, plan[i].typed, plan[i].want, got);
    end

    // Random part: each phase picks a pool shape, usually rebuilds, then runs
    // mostly alloc/free traffic against the slots handed out so far.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      quiet = (p % 4 == 2);
      r = $urandom_range(0, 9);
      if (r == 0)
        write_reg(REG_SLOT_COUNT, 13'd1);
      else if (r == 1)
        write_reg(REG_SLOT_COUNT, 13'd1024);
      else if (r == 2)
        write_reg(REG_SLOT_COUNT, CFG_DAT_W'($urandom_range(1025, 2047)));
      else
        write_reg(REG_SLOT_COUNT, CFG_DAT_W'($urandom_range(2, 48)));
      if (p % 2 == 0) begin
        r = $urandom_range(0, 5);
        if (r == 0)
          write_reg(REG_SLOT_SIZE, 13'd8);
        else if (r == 1)
          write_reg(REG_SLOT_SIZE, 13'd4096);
        else
          write_reg(REG_SLOT_SIZE, CFG_DAT_W'($urandom_range(8, 4096)));
      end
      // now and then keep the old chain across a count change
      if ($urandom_range(0, 9) != 0)
        send(ACT_REBUILD, SLOT_W'($urandom_range(0, 1023)));

      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        lim = live_count();
        r   = $urandom_range(0, 99);
        if (r < 44) begin
          send(ACT_ALLOC, SLOT_W'($urandom_range(0, 1023)));
        end else if (r < 84) begin
          sel = $urandom_range(0, 9);
          if (held_slots.size() != 0 && sel < 7) begin
            idx  = $urandom_range(0, held_slots.size() - 1);
            pick = held_slots[idx];
            held_slots.delete(idx);
          end else if (held_slots.size() != 0 && sel == 7) begin
            // leave it in the list: a later free of it is a double free
            pick = held_slots[$urandom_range(0, held_slots.size() - 1)];
          end else if (sel == 8 || lim == 0) begin
            pick = SLOT_W'($urandom_range(0, 1023));
          end else if ($urandom_range(0, 1) == 0) begin
            pick = SLOT_W'(lim - 1);          // last slot in range
          end else begin
            pick = SLOT_W'((lim > 1023) ? 1023 : lim);  // first slot past the end; else 1023
          end
          send(ACT_FREE, pick);
        end else if (r < 96) begin
          send(ACT_REBUILD, SLOT_W'($urandom_range(0, 1023)));
        end else begin
          send(ACT_UNUSED, SLOT_W'($urandom_range(0, 1023)));
        end
      end
      // hold the command side off until the pool has answered everything
      settle();
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending_grants.size() == 0) begin
      $display("free_list_slot_allocator test passed");
    end else begin
      $display("free_list_slot_allocator test failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("free_list_slot_allocator test failed");
    $finish;
  end

endmodule
